// ----- src/sws_pkg.sv -----
// Shared types and constants for the even/odd sine waveshaper.
`default_nettype none

package sws_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W    = 16;
    localparam int PAD_W       = 16;
    localparam int GAIN_W      = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int PHASE_W    = 24;
    localparam int INDEX_CLIP = 12;

    localparam int QUEUE_DEPTH = 8;
    localparam int OUT_DEPTH   = 4;

    localparam logic [PAD_W-1:0]  DEF_INPUT_PAD = 16'd4096;
    localparam logic [GAIN_W-1:0] DEF_EVEN_GAIN = 24'd65536;
    localparam logic [GAIN_W-1:0] DEF_ODD_GAIN  = 24'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INPUT_PAD = 2'd0,
        REG_EVEN_GAIN = 2'd1,
        REG_ODD_GAIN  = 2'd2
    } sws_reg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] even_phase;
        logic [PHASE_W-1:0] odd_phase;
        logic               neg;
    } sws_item_t;

    typedef struct packed {
        logic      valid;
        sws_item_t item;
    } sws_entry_t;

endpackage

`default_nettype wire

// ----- src/sws_in_if.sv -----
// Sample input channel.
`default_nettype none

interface sws_in_if
    import sws_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ----- src/sws_out_if.sv -----
// Shaped sample output channel.
`default_nettype none

interface sws_out_if
    import sws_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- src/sws_cfg_if.sv -----
// Configuration register write channel.
`default_nettype none

interface sws_cfg_if
    import sws_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/sws_front.sv -----
// Front end: config registers, pad gain and even/odd phase computation.
`default_nettype none

module sws_front
    import sws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sws_in_if.sink     sample_chan,
    sws_cfg_if.sink    cfg,
    input  wire logic  pop,
    output sws_entry_t entry
);

    localparam int UW = $clog2(QUEUE_DEPTH + 1);

    logic [PAD_W-1:0]  pad_reg;
    logic [GAIN_W-1:0] even_gain_reg;
    logic [GAIN_W-1:0] odd_gain_reg;

    logic [UW-1:0] used_reg;
    logic [UW-1:0] used_next;
    logic [3:0]    vld_reg;
    logic          accept;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [32:0]         u;
    logic [32:0]                u_abs;
    logic [30:0]                mag_reg;
    logic                       neg2_reg;
    logic [61:0]                sq;
    logic [31:0]                sq_reg;
    logic [54:0]                op_reg;
    logic                       neg3_reg;
    logic [55:0]                ep_reg;
    logic [57:0]                od6;
    logic [38:0]                od;
    logic [PHASE_W-1:0]         od_phase;
    logic [PHASE_W-1:0]         od_phase_reg;
    logic                       neg4_reg;
    logic [58:0]                ev6;
    logic [42:0]                ev;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg       <= DEF_INPUT_PAD;
            even_gain_reg <= DEF_EVEN_GAIN;
            odd_gain_reg  <= DEF_ODD_GAIN;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INPUT_PAD: pad_reg       <= cfg.data[PAD_W-1:0];
                REG_EVEN_GAIN: even_gain_reg <= cfg.data[GAIN_W-1:0];
                REG_ODD_GAIN:  odd_gain_reg  <= cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // outstanding = in the front pipe plus in the queue
    assign sample_chan.ready = (used_reg < UW'(QUEUE_DEPTH));
    assign accept            = sample_chan.valid && sample_chan.ready;

    always_comb
    begin
        used_next = used_reg;
        if (accept && !pop)
        begin
            used_next = used_reg + UW'(1);
        end
        else if (!accept && pop)
        begin
            used_next = used_reg - UW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            vld_reg  <= {vld_reg[2:0], accept};
        end
    end

    assign u     = x_reg * $signed({1'b0, pad_reg});
    assign u_abs = u[32] ? 33'(-u) : 33'(u);
    assign sq    = mag_reg * mag_reg;

    assign od6      = {1'b0, op_reg, 2'b00} + {2'b00, op_reg, 1'b0};
    assign od       = od6[57:19];
    assign od_phase = (od[38:PHASE_W] >= 15'(INDEX_CLIP)) ? '0 : od[PHASE_W-1:0];

    assign ev6 = {1'b0, ep_reg, 2'b00} + {2'b00, ep_reg, 1'b0};
    assign ev  = ev6[58:16];

    always_ff @(posedge clk)
    begin
        x_reg        <= sample_chan.sample_in;
        mag_reg      <= u_abs[30:0];
        neg2_reg     <= u[32];
        sq_reg       <= sq[61:30];
        op_reg       <= mag_reg * odd_gain_reg;
        neg3_reg     <= neg2_reg;
        ep_reg       <= sq_reg * even_gain_reg;
        od_phase_reg <= od_phase;
        neg4_reg     <= neg3_reg;
    end

    assign entry.valid           = vld_reg[3];
    assign entry.item.even_phase = (ev[42:PHASE_W] >= 19'(INDEX_CLIP)) ? '0 : ev[PHASE_W-1:0];
    assign entry.item.odd_phase  = od_phase_reg;
    assign entry.item.neg        = neg4_reg;

endmodule

`default_nettype wire

// ----- src/sws_queue.sv -----
// Decoupling queue between the front end and the sine back end.
`default_nettype none

module sws_queue
    import sws_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sws_entry_t push_entry,
    input  wire logic       pop,
    output sws_entry_t      head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    sws_item_t     mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push_entry.valid && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push_entry.valid && pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_entry.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_entry.valid)
        begin
            mem[wr_ptr_reg] <= push_entry.item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- src/sws_sine.sv -----
// Sine of 2*pi*phase from a quarter-wave table with linear interpolation.
`default_nettype none

module sws_sine
    import sws_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic [PHASE_W-1:0] phase,
    input  wire logic               flip,
    output logic signed [15:0]      sine
);

    localparam int FB        = 22 - SINE_TABLE_BITS;
    localparam int AW        = SINE_TABLE_BITS + 1;
    localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HORNER_D0   = 64'd156;
    localparam longint unsigned HORNER_D1   = 64'd110;
    localparam longint unsigned HORNER_D2   = 64'd72;
    localparam longint unsigned HORNER_D3   = 64'd42;
    localparam longint unsigned HORNER_D4   = 64'd20;
    localparam longint unsigned HORNER_D5   = 64'd6;

    localparam logic [15+FB:0] HALF = (16 + FB)'(1) << (FB - 1);

    typedef logic [14:0] rom_t [ROM_DEPTH];

    function automatic logic [14:0] rom_entry(input longint unsigned k);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        a  = (HALF_PI_Q30 * k) >> SINE_TABLE_BITS;
        a2 = (a * a) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((a2 * t) >> 30) / HORNER_D0;
        t  = ONE_Q30 - ((a2 * t) >> 30) / HORNER_D1;
        t  = ONE_Q30 - ((a2 * t) >> 30) / HORNER_D2;
        t  = ONE_Q30 - ((a2 * t) >> 30) / HORNER_D3;
        t  = ONE_Q30 - ((a2 * t) >> 30) / HORNER_D4;
        t  = ONE_Q30 - ((a2 * t) >> 30) / HORNER_D5;
        s  = (a * t) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    function automatic rom_t rom_fill();
        rom_t r;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            r[k] = rom_entry(longint'(k));
        end
        return r;
    endfunction

    localparam rom_t ROM = rom_fill();

    logic [1:0]    quad;
    logic [22:0]   rm;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    logic [14:0]    rom_a_reg;
    logic [14:0]    rom_b_reg;
    logic [FB-1:0]  frac_reg;
    logic           neg1_reg;

    logic [14:0]    diff;
    logic [14+FB:0] prod;
    logic [15+FB:0] rnd;
    logic [14:0]    val;

    assign quad   = phase[PHASE_W-1:PHASE_W-2];
    assign rm     = quad[0] ? (23'd1 << 22) - {1'b0, phase[21:0]} : {1'b0, phase[21:0]};
    assign addr_a = rm[22:FB];
    // peak entry has no successor
    assign addr_b = addr_a[AW-1] ? addr_a : addr_a + AW'(1);

    always_ff @(posedge clk)
    begin
        rom_a_reg <= ROM[addr_a];
        rom_b_reg <= ROM[addr_b];
        frac_reg  <= rm[FB-1:0];
        neg1_reg  <= quad[1] ^ flip;
    end

    assign diff = rom_b_reg - rom_a_reg;
    assign prod = diff * frac_reg;
    assign rnd  = {1'b0, prod} + HALF;
    assign val  = rom_a_reg + rnd[FB+14:FB];

    always_ff @(posedge clk)
    begin
        sine <= neg1_reg ? -$signed({1'b0, val}) : $signed({1'b0, val});
    end

endmodule

`default_nettype wire

// ----- src/sws_back.sv -----
// Back end: two sine lookups, averaging and the output buffer.
`default_nettype none

module sws_back
    import sws_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sws_entry_t head,
    output logic            pop,
    sws_out_if.source       result_chan
);

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [CW-1:0] bused_reg;
    logic [CW-1:0] bused_next;
    logic [2:0]    b_vld_reg;
    logic          take;

    logic signed [15:0] even_sine;
    logic signed [15:0] odd_sine;
    logic signed [16:0] sum;
    logic signed [15:0] avg_reg;

    logic signed [SAMPLE_W-1:0] ofifo [OUT_DEPTH];
    logic [PW-1:0]              owr_reg;
    logic [PW-1:0]              ord_reg;
    logic [CW-1:0]              ocnt_reg;
    logic [CW-1:0]              ocnt_next;

    // outstanding = in the sine pipe plus in the output buffer
    assign take = result_chan.valid && result_chan.ready;
    assign pop  = head.valid && ((bused_reg < CW'(OUT_DEPTH)) || take);

    always_comb
    begin
        bused_next = bused_reg;
        if (pop && !take)
        begin
            bused_next = bused_reg + CW'(1);
        end
        else if (!pop && take)
        begin
            bused_next = bused_reg - CW'(1);
        end
        ocnt_next = ocnt_reg;
        if (b_vld_reg[2] && !take)
        begin
            ocnt_next = ocnt_reg + CW'(1);
        end
        else if (!b_vld_reg[2] && take)
        begin
            ocnt_next = ocnt_reg - CW'(1);
        end
    end

    sws_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_even (
        .clk   (clk),
        .phase (head.item.even_phase),
        .flip  (1'b0),
        .sine  (even_sine)
    );

    sws_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_odd (
        .clk   (clk),
        .phase (head.item.odd_phase),
        .flip  (head.item.neg),
        .sine  (odd_sine)
    );

    assign sum = 17'(even_sine) + 17'(odd_sine);

    always_ff @(posedge clk)
    begin
        avg_reg <= 16'(sum >>> 1);
        if (b_vld_reg[2])
        begin
            ofifo[owr_reg] <= avg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bused_reg <= '0;
            b_vld_reg <= '0;
            owr_reg   <= '0;
            ord_reg   <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            bused_reg <= bused_next;
            b_vld_reg <= {b_vld_reg[1:0], pop};
            ocnt_reg  <= ocnt_next;
            if (b_vld_reg[2])
            begin
                owr_reg <= owr_reg + PW'(1);
            end
            if (take)
            begin
                ord_reg <= ord_reg + PW'(1);
            end
        end
    end

    assign result_chan.valid      = (ocnt_reg != '0);
    assign result_chan.sample_out = ofifo[ord_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg[2] |-> (ocnt_reg < CW'(OUT_DEPTH)))
        else $error("output buffer written while full");

    a_credit_match: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(bused_reg) == 32'(ocnt_reg) + $countones(b_vld_reg)))
        else $error("back-end credit count out of step");

    a_valid_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_chan.valid) |-> $past(result_chan.ready))
        else $error("result withdrawn without a transaction");
`endif

endmodule

`default_nettype wire

// ----- src/even_odd_sine_waveshaper.sv -----
// Even/odd sine waveshaper top level.
`default_nettype none

// Accepts one Q1.15 sample per clock while ready is high and returns one Q1.15
// sample per sample, in order. From its input transaction to its result being
// offered, a sample passes 4 front-end stages (pad gain, square and odd gain,
// even gain, clip), the queue, 3 back-end stages (table read, interpolation,
// averaging) and the output buffer. Throughput is one sample per clock while
// results are taken; input ready drops only once 8 samples sit between the
// input and the queue head, and the back end stops popping once 4 samples are
// in the sine pipe and output buffer and no result leaves in that cycle. Each
// path owns a sine table of 2^SINE_TABLE_BITS+1 entries read at two addresses
// per clock. Configuration writes take effect on the next clock and must be
// made while no sample is in flight.
module even_odd_sine_waveshaper
    import sws_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    sws_in_if.sink    sample_chan,
    sws_out_if.source result_chan,
    sws_cfg_if.sink   cfg
);

    sws_entry_t front_entry;
    sws_entry_t queue_head;
    logic       pop;

    sws_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_chan (sample_chan),
        .cfg         (cfg),
        .pop         (pop),
        .entry       (front_entry)
    );

    sws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (queue_head)
    );

    sws_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (queue_head),
        .pop         (pop),
        .result_chan (result_chan)
    );

endmodule

`default_nettype wire

// ----- tb/even_odd_sine_waveshaper_tb.sv -----
// Self-checking testbench for the even/odd sine waveshaper, with its own predictor.
`default_nettype none

module even_odd_sine_waveshaper_tb;
    import sws_pkg::*;

    typedef longint unsigned u64_t;

    localparam int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF;
    localparam int QUARTER_BITS    = 22;
    localparam int FRAC_BITS       = QUARTER_BITS - SINE_TABLE_BITS;
    localparam int ROM_LAST        = 1 << SINE_TABLE_BITS;
    localparam int PIPE_LATENCY    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 100;

    localparam u64_t HALF_PI_Q30 = 64'd1686629713;
    localparam u64_t ONE_Q30     = u64_t'(1) << 30;
    localparam u64_t CLIP_LIMIT  = u64_t'(INDEX_CLIP) << PHASE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    logic clk;
    logic rst_n;

    sws_in_if  sample_chan ();
    sws_out_if result_chan ();
    sws_cfg_if cfg ();

    even_odd_sine_waveshaper #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_chan (sample_chan),
        .result_chan (result_chan),
        .cfg         (cfg)
    );

    // predictor copy of the registers
    logic [PAD_W-1:0]  pad_reg  = DEF_INPUT_PAD;
    logic [GAIN_W-1:0] even_reg = DEF_EVEN_GAIN;
    logic [GAIN_W-1:0] odd_reg  = DEF_ODD_GAIN;

    u64_t sine_rom [0:ROM_LAST];

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] expected_head;

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatches     = 0;
    int results_checked = 0;
    int items_accepted  = 0;
    int cfg_writes      = 0;
    int cycle_count     = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // quarter-wave table, Q30 Horner series with truncation at every step
    initial
    begin
        u64_t a;
        u64_t a2;
        u64_t term;
        u64_t s;
        u64_t v;
        int   i;
        for (int k = 0; k <= ROM_LAST; k++)
        begin
            a    = (HALF_PI_Q30 * u64_t'(k)) >> SINE_TABLE_BITS;
            a2   = (a * a) >> 30;
            term = ONE_Q30;
            for (i = 0; i < 6; i++)
                term = ONE_Q30 - ((a2 * term) >> 30) / u64_t'((12 - 2 * i) * (13 - 2 * i));
            s = (a * term) >> 30;
            v = (s * u64_t'(32767) + (u64_t'(1) << 29)) >> 30;
            sine_rom[k] = (v > u64_t'(32767)) ? u64_t'(32767) : v;
        end
    end

    function automatic longint sine_of_index(input u64_t idx);
        u64_t phase;
        u64_t quad;
        u64_t r;
        u64_t i;
        u64_t f;
        u64_t a;
        u64_t b;
        u64_t v;
        phase = idx & ((u64_t'(1) << PHASE_W) - 1);
        quad  = phase >> QUARTER_BITS;
        r     = phase & ((u64_t'(1) << QUARTER_BITS) - 1);
        if (quad[0])
            r = (u64_t'(1) << QUARTER_BITS) - r;
        i = r >> FRAC_BITS;
        f = r & ((u64_t'(1) << FRAC_BITS) - 1);
        a = sine_rom[i];
        b = a;
        if (i < u64_t'(ROM_LAST))
            b = sine_rom[i + 1];
        v = a + (((b - a) * f + (u64_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] shape_sample(
        input logic signed [SAMPLE_W-1:0] s
    );
        longint u;
        longint pad;
        longint even_sine;
        longint odd_sine;
        longint total;
        u64_t   mag;
        u64_t   even_idx;
        u64_t   odd_idx;
        logic   neg;
        u   = s;
        pad = pad_reg;
        u   = u * pad;
        neg = (u < 0);
        mag = neg ? u64_t'(-u) : u64_t'(u);

        even_idx = (((mag * mag) >> 30) * u64_t'(even_reg) * u64_t'(6)) >> 16;
        if (even_idx > CLIP_LIMIT)
            even_idx = CLIP_LIMIT;
        even_sine = sine_of_index(even_idx);

        odd_idx = (mag * u64_t'(odd_reg) * u64_t'(6)) >> 19;
        if (odd_idx > CLIP_LIMIT)
            odd_idx = CLIP_LIMIT;
        odd_sine = sine_of_index(odd_idx);
        if (neg)
            odd_sine = -odd_sine;

        total = (even_sine + odd_sine) >>> 1;
        return total[SAMPLE_W-1:0];
    endfunction

    // receiver back-pressure
    always @(posedge clk)
        result_chan.ready <= ($urandom_range(99) >= stall_pct);

    // result check, then capture of the new transaction
    always @(posedge clk)
    begin
        if (result_chan.valid && result_chan.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, result_chan.sample_out);
                mismatches++;
            end
            else
            begin
                expected_head = expected_samples.pop_front();
                results_checked++;
                if (expected_head !== result_chan.sample_out)
                begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, expected_head, result_chan.sample_out);
                    mismatches++;
                end
            end
        end
        if (sample_chan.valid && sample_chan.ready)
        begin
            expected_samples.push_back(shape_sample(sample_chan.sample_in));
            items_accepted++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results outstanding", $time, expected_samples.size());
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_chan.valid <= 1'b0;
            @(posedge clk);
        end
        sample_chan.valid     <= 1'b1;
        sample_chan.sample_in <= s;
        @(posedge clk);
        while (!sample_chan.ready)
            @(posedge clk);
    endtask

    task automatic drain(input int extra_cycles);
        sample_chan.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    task automatic write_register(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  value
    );
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_INPUT_PAD: pad_reg  = value[PAD_W-1:0];
            REG_EVEN_GAIN: even_reg = value[GAIN_W-1:0];
            REG_ODD_GAIN:  odd_reg  = value[GAIN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_config(
        input logic [CFG_DATA_W-1:0] pad,
        input logic [GAIN_W-1:0]     even_gain,
        input logic [GAIN_W-1:0]     odd_gain
    );
        drain(PIPE_LATENCY);
        write_register(REG_INPUT_PAD, pad);
        write_register(REG_EVEN_GAIN, even_gain);
        write_register(REG_ODD_GAIN, odd_gain);
        cfg.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
    endtask

    // quarter-wave peaks on both paths, then indexes of exactly 12, at the clip bound
    task automatic test_peak_and_full_index();
        apply_config(24'd4096, 24'd32768, 24'd49152);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
        apply_config(24'd4096, 24'd65536, 24'd16384);
        send_sample(16'sd16384);
        apply_config(24'd4096, 24'd524288, 24'd262144);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
    endtask

    task automatic test_extreme_gains();
        apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        apply_config(24'd0, 24'd0, 24'd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
    endtask

    task automatic test_unmapped_register();
        apply_config(24'd6000, 24'd90000, 24'd70000);
        @(posedge clk);
        write_register(REG_UNMAPPED, 24'($urandom));
        cfg.valid <= 1'b0;
        repeat (4) send_sample(16'($urandom));
    endtask

    task automatic test_random_phases();
        logic signed [SAMPLE_W-1:0] s;
        int pick;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: apply_config(24'(DEF_INPUT_PAD), DEF_EVEN_GAIN, DEF_ODD_GAIN);
                1: apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                3: apply_config(24'd0, 24'd0, 24'd0);
                4, 6: apply_config(24'($urandom_range(0, 24'hFFFFFF)),
                                   24'($urandom_range(0, 24'hFFFFFF)),
                                   24'($urandom_range(0, 24'hFFFFFF)));
                default: apply_config(24'($urandom_range(1024, 8192)),
                                      24'($urandom_range(4096, 196608)),
                                      24'($urandom_range(4096, 196608)));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain(0);
                pick = $urandom_range(99);
                if (pick < 60)
                    s = 16'($urandom);
                else if (pick < 85)
                    s = 16'($urandom_range(0, 2047) - 1024);
                else
                begin
                    case ($urandom_range(5))
                        0: s = -16'sd32768;
                        1: s = -16'sd32767;
                        2: s = -16'sd1;
                        3: s = 16'sd0;
                        4: s = 16'sd1;
                        default: s = 16'sd32767;
                    endcase
                end
                send_sample(s);
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        sample_chan.valid     <= 1'b0;
        sample_chan.sample_in <= '0;
        cfg.valid             <= 1'b0;
        cfg.index             <= REG_INPUT_PAD;
        cfg.data              <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_peak_and_full_index();
        test_extreme_gains();
        test_unmapped_register();
        test_random_phases();

        drain(2 * PIPE_LATENCY);
        $display("Covered %0d samples and %0d register writes: reset gains, peaks, clipping,",
                 items_accepted, cfg_writes);
        $display("zero and full-scale gains, random gains, idle and stall phases; %0d checked",
                 results_checked);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
